>>> rtl/pleng_pkg.sv
// shared types and constants for the positional list engine
// opcode and status codes, cell control group, default sizes; no dependencies
`timescale 1ns / 1ps

package pleng_pkg;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_DATA_WIDTH = 32;
    localparam int OP_W           = 4;
    localparam int ST_W           = 2;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND    = 4'd0,
        OP_PUSH      = 4'd1,
        OP_INSERT_AT = 4'd2,
        OP_POP_FRONT = 4'd3,
        OP_POP_BACK  = 4'd4,
        OP_REMOVE_AT = 4'd5,
        OP_READ_AT   = 4'd6,
        OP_SEARCH    = 4'd7,
        OP_CLEAR     = 4'd8
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // per-request control broadcast to every cell
    typedef struct packed {
        logic ins;   // open a gap at the index and write the value there
        logic del;   // close the gap at the index
        logic tap;   // cell at the index drives its entry to the reduction
        logic srch;  // every valid cell compares against the value
    } t_cell_ctl;

endpackage

>>> rtl/positional_list_engine.sv
// top level of the positional list engine: request decode, cell row, reduction, result
// depends on pleng_pkg, pleng_cell and pleng_or_tree
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed values kept in a row of cells, one entry per
// cell. Inserts and removals shift the cells next to each other in the cycle the
// request is taken; reads and searches tap every cell at once and the taps are
// merged in a registered or-tree. One request is handled at a time: the cell taps
// are registered, merged through the registered levels of the reduction tree and
// captured in the result register. The next request is taken in the cycle after
// the result has been handed off, so no new request is taken before the last one's
// result is out. Every request gives one result with status, removed or read value,
// search hit, count and empty flag. Entries need no clearing after reset; only cells
// below the count are ever read.
module positional_list_engine #(
    parameter int CAPACITY   = pleng_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = pleng_pkg::DEF_DATA_WIDTH,
    localparam int PW        = $clog2(CAPACITY),
    localparam int CW        = $clog2(CAPACITY + 1),
    localparam int IN_BITS   = pleng_pkg::OP_W + PW + DATA_WIDTH,
    localparam int IN_TW     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS  = pleng_pkg::ST_W + DATA_WIDTH + 1 + CW + 1,
    localparam int OUT_TW    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // from bit 0: opcode, position, data_in, zero fill
    input  logic [IN_TW-1:0]  s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // from bit 0: status, data_out, found, count, is_empty, zero fill
    output logic [OUT_TW-1:0] m_tdata
);
    import pleng_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int LV = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE = CW'(1);

    // request fields
    logic [OP_W-1:0]      w_opcode;
    logic [PW-1:0]        w_position;
    logic signed [DW-1:0] w_data_in;
    logic                 w_accept;

    assign w_opcode   = s_tdata[OP_W-1:0];
    assign w_position = s_tdata[OP_W+PW-1:OP_W];
    assign w_data_in  = s_tdata[OP_W+PW+DW-1:OP_W+PW];
    assign w_accept   = s_tvalid && s_tready;

    // control state
    logic            r_busy, n_busy;
    logic [CW-1:0]   r_len, n_len;
    logic [LV:0]     r_pipe;
    t_status         r_pend_status;

    // decode results
    t_cell_ctl       w_ctl, w_ctl_req;
    t_status         w_status;
    logic [PW-1:0]   w_at;
    logic            w_full, w_empty, w_past;

    assign w_full  = (r_len == CAP);
    assign w_empty = (r_len == '0);
    assign w_past  = (CW'(w_position) >= r_len);

    always_comb begin
        w_ctl_req = '0;
        w_status  = ST_OK;
        w_at      = w_position;
        n_len     = r_len;
        unique case (t_op'(w_opcode)) inside
            OP_APPEND: begin
                w_at = r_len[PW-1:0];
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctl_req.ins = 1'b1;
                    n_len         = r_len + ONE;
                end
            end
            OP_PUSH: begin
                w_at = '0;
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctl_req.ins = 1'b1;
                    n_len         = r_len + ONE;
                end
            end
            OP_INSERT_AT: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_past) begin
                    w_status = ST_RANGE;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctl_req.ins = 1'b1;
                    n_len         = r_len + ONE;
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                // pop back taps the last valid cell, pop front the head
                w_at = (t_op'(w_opcode) == OP_POP_BACK) ? PW'(r_len - ONE) : '0;
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_ctl_req.del = 1'b1;
                    w_ctl_req.tap = 1'b1;
                    n_len         = r_len - ONE;
                end
            end
            OP_REMOVE_AT: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_past) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctl_req.del = 1'b1;
                    w_ctl_req.tap = 1'b1;
                    n_len         = r_len - ONE;
                end
            end
            OP_READ_AT: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_past) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctl_req.tap = 1'b1;
                end
            end
            OP_SEARCH: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_ctl_req.srch = 1'b1;
                end
            end
            OP_CLEAR: begin
                n_len = '0;
            end
            default: begin
                // unused opcodes leave the list alone and report ok
            end
        endcase
    end

    // cells only see a request in its accept cycle
    assign w_ctl = w_accept ? w_ctl_req : '0;

    // cell row
    logic [DW-1:0] w_entry [CAPACITY];
    logic [DW-1:0] w_tap   [CAPACITY];
    logic          w_hit   [CAPACITY];
    logic [DW:0]   w_leaf  [CAPACITY];
    logic [DW:0]   w_root;

    for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
        logic [DW-1:0] w_left, w_right;
        if (c == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[c-1];
        end
        if (c == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_entry[c+1];
        end

        pleng_cell #(
            .INDEX (c),
            .PW    (PW),
            .CW    (CW),
            .DW    (DW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_at    (w_at),
            .i_len   (r_len),
            .i_val   (w_data_in),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[c]),
            .o_tap   (w_tap[c]),
            .o_hit   (w_hit[c])
        );

        // search hit rides in the top bit next to the tapped value
        assign w_leaf[c] = {w_hit[c], w_tap[c]};
    end

    // merge taps and hits: root is registered at the last level of the tree
    pleng_or_tree #(
        .N (CAPACITY),
        .W (DW + 1)
    ) u_tree (
        .i_clk  (i_clk),
        .i_leaf (w_leaf),
        .o_root (w_root)
    );

    // one request in flight; busy until its result is handed off, nothing taken in reset
    assign s_tready = i_rst_n && !r_busy;

    always_comb begin
        n_busy = r_busy;
        if (w_accept) begin
            n_busy = 1'b1;
        end else if (m_tvalid && m_tready) begin
            n_busy = 1'b0;
        end
    end

    // result register
    t_status       r_status;
    logic [DW-1:0] r_data;
    logic          r_found;
    logic [CW-1:0] r_count;
    logic          r_is_empty;
    logic          r_m_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_len     <= '0;
            r_pipe    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (w_accept) begin
                r_len <= n_len;
            end
            r_pipe <= {r_pipe[LV-1:0], w_accept};
            if (r_pipe[LV]) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pend_status <= w_status;
        end
        if (r_pipe[LV]) begin
            r_status   <= r_pend_status;
            r_data     <= w_root[DW-1:0];
            r_found    <= w_root[DW];
            r_count    <= r_len;
            r_is_empty <= (r_len == '0);
        end
    end

    assign m_tvalid = r_m_valid;

    always_comb begin
        m_tdata = '0;
        m_tdata[ST_W-1:0]                    = r_status;
        m_tdata[ST_W+DW-1:ST_W]              = r_data;
        m_tdata[ST_W+DW]                     = r_found;
        m_tdata[ST_W+DW+CW:ST_W+DW+1]        = r_count;
        m_tdata[ST_W+DW+CW+1]                = r_is_empty;
    end

    // the count never passes the capacity
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= CAP)
        else $error("list count beyond capacity");

    // a taken request keeps the engine busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_busy)
        else $error("request taken but engine not busy");

    // a result is only shown for a request in flight
    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> r_busy)
        else $error("result valid with no request in flight");

    // the count holds while a request is being worked on
    a_len_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && $past(r_busy)) |-> $stable(r_len))
        else $error("count changed while busy");

    // a handed-off result frees the engine
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tready) |=> (!m_tvalid && s_tready))
        else $error("engine not released after result");

endmodule

>>> rtl/pleng_cell.sv
// one storage cell of the list: holds a single entry and shifts with its neighbors
// depends on pleng_pkg for the cell control struct
`timescale 1ns / 1ps

module pleng_cell #(
    parameter int INDEX = 0,
    parameter int PW    = 6,
    parameter int CW    = 7,
    parameter int DW    = 32
) (
    input  logic                 i_clk,
    input  pleng_pkg::t_cell_ctl i_ctl,
    input  logic [PW-1:0]        i_at,
    input  logic [CW-1:0]        i_len,
    input  logic [DW-1:0]        i_val,
    input  logic [DW-1:0]        i_left,
    input  logic [DW-1:0]        i_right,
    output logic [DW-1:0]        o_entry,
    output logic [DW-1:0]        o_tap,
    output logic                 o_hit
);
    import pleng_pkg::*;

    localparam logic [CW-1:0] IDX = CW'(INDEX);

    logic [DW-1:0] r_entry, n_entry;
    logic [DW-1:0] r_tap;
    logic          r_hit;
    logic [CW-1:0] w_at;

    assign w_at = CW'(i_at);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (IDX > w_at) begin
                n_entry = i_left;
            end else if (IDX == w_at) begin
                n_entry = i_val;
            end
        end else if (i_ctl.del) begin
            if (IDX >= w_at) begin
                n_entry = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_tap   <= (i_ctl.tap && IDX == w_at) ? r_entry : '0;
        r_hit   <= i_ctl.srch && (IDX < i_len) && (r_entry == i_val);
    end

    assign o_entry = r_entry;
    assign o_tap   = r_tap;
    assign o_hit   = r_hit;

endmodule

>>> rtl/pleng_or_tree.sv
// registered binary or-reduction over the cell outputs, one register per tree level
// self-contained; every tree level from the leaves to the root is registered
`timescale 1ns / 1ps

module pleng_or_tree #(
    parameter int N = 64,
    parameter int W = 33
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_leaf [N],
    output logic [W-1:0] o_root
);
    localparam int LV = $clog2(N);
    localparam int NP = 1 << LV;
    localparam int NI = NP - 1;

    logic [W-1:0] w_leaf [NP];
    logic [W-1:0] r_node [NI];

    for (genvar j = 0; j < NP; j++) begin : g_pad
        if (j < N) begin : g_real
            assign w_leaf[j] = i_leaf[j];
        end else begin : g_zero
            assign w_leaf[j] = '0;
        end
    end

    // heap layout: node k has children 2k+1 and 2k+2, leaves follow the inner nodes
    for (genvar k = 0; k < NI; k++) begin : g_node
        if (2 * k + 1 >= NI) begin : g_bottom
            always_ff @(posedge i_clk) begin
                r_node[k] <= w_leaf[2*k+1-NI] | w_leaf[2*k+2-NI];
            end
        end else begin : g_inner
            always_ff @(posedge i_clk) begin
                r_node[k] <= r_node[2*k+1] | r_node[2*k+2];
            end
        end
    end

    assign o_root = r_node[0];

endmodule
